// ----- hw/rtl/url_span_finder_macros.svh -----
// Assertion macros used by the checker file of the URL span finder.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef URL_SPAN_FINDER_MACROS_SVH
`define URL_SPAN_FINDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define USF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define USF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/usf_pkg.sv -----
// Shared types, character codes and helpers for the URL span finder.
// No dependencies; front, queue, back, top, checker and bench refer to it by scope.
package usf_pkg;

    localparam int MAX_LINE_LEN_DEFAULT = 4096;
    localparam int HIST_DEPTH           = 5;
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [15:0] CH_COLON = 16'd58;
    localparam logic [15:0] CH_H     = 16'd104;
    localparam logic [15:0] CH_T     = 16'd116;
    localparam logic [15:0] CH_P     = 16'd112;
    localparam logic [15:0] CH_S     = 16'd115;
    localparam logic [15:0] CH_F     = 16'd102;
    localparam logic [15:0] CH_TILDE = 16'd126;
    localparam logic [15:0] CH_UNDER = 16'd95;
    localparam logic [15:0] CH_BANG  = 16'd33;
    localparam logic [15:0] CH_EQ    = 16'd61;
    localparam logic [15:0] CH_STAR  = 16'd42;
    localparam logic [15:0] CH_QUEST = 16'd63;
    localparam logic [15:0] CH_HASH  = 16'd35;

    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_FTP   = 3'd4;
    localparam logic [2:0] LEN_HTTP  = 3'd5;
    localparam logic [2:0] LEN_HTTPS = 3'd6;

    typedef struct packed {
        logic [15:0] ch;
        logic [12:0] search_from;
        logic        last_of_line;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [11:0] span_begin;
        logic [12:0] span_end;
        logic        line_done;
    } out_item_t;

    function automatic logic is_url_char(input logic [15:0] c);
        logic hit;
        hit = (c == CH_TILDE) || (c == CH_UNDER) || (c == CH_BANG) || (c == CH_EQ) ||
              (c == CH_STAR) || (c == CH_QUEST) || (c == CH_HASH) ||
              (c >= 16'd97 && c <= 16'd122) || (c >= 16'd65 && c <= 16'd90) ||
              (c >= 16'd44 && c <= 16'd59) || (c >= 16'd36 && c <= 16'd38);
        return hit;
    endfunction

endpackage

// ----- hw/rtl/usf_chan_if.sv -----
// Valid/ready channel carrying one request payload of a given type.
// Depends on nothing; payload types come from usf_pkg at the instance.
interface usf_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/usf_front.sv -----
// Front end: accepts characters, tracks line position and history, and
// classifies each character for the back end. Depends on usf_pkg, usf_chan_if.
module usf_front #(
    parameter int  MAX_LEN = usf_pkg::MAX_LINE_LEN_DEFAULT,
    parameter int  POS_W   = $clog2(MAX_LEN + 1),
    parameter type cls_t   = logic
) (
    input  logic        clk,
    input  logic        rst_n,
    usf_chan_if.sink    chars,
    input  logic        q_full,
    output logic        q_push,
    output cls_t        q_entry
);

    localparam int CMP_W = (POS_W > 13) ? POS_W : 13;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      hist_reg [usf_pkg::HIST_DEPTH];
    logic [15:0]      hist_next [usf_pkg::HIST_DEPTH];

    logic [15:0]      c;
    logic             below_cap;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] start_pos;
    logic [2:0]       len;
    logic             match_https, match_http, match_ftp;

    always_comb
    begin
        c         = chars.payload.ch;
        below_cap = (pos_reg != POS_W'(MAX_LEN));
        pos_inc   = pos_reg + POS_W'(1);

        match_https = (hist_reg[0] == usf_pkg::CH_S) && (hist_reg[1] == usf_pkg::CH_P) &&
                      (hist_reg[2] == usf_pkg::CH_T) && (hist_reg[3] == usf_pkg::CH_T) &&
                      (hist_reg[4] == usf_pkg::CH_H);
        match_http  = (hist_reg[0] == usf_pkg::CH_P) && (hist_reg[1] == usf_pkg::CH_T) &&
                      (hist_reg[2] == usf_pkg::CH_T) && (hist_reg[3] == usf_pkg::CH_H);
        match_ftp   = (hist_reg[0] == usf_pkg::CH_P) && (hist_reg[1] == usf_pkg::CH_T) &&
                      (hist_reg[2] == usf_pkg::CH_F);

        if (c != usf_pkg::CH_COLON)
            len = usf_pkg::LEN_NONE;
        else if (match_https)
            len = usf_pkg::LEN_HTTPS;
        else if (match_http)
            len = usf_pkg::LEN_HTTP;
        else if (match_ftp)
            len = usf_pkg::LEN_FTP;
        else
            len = usf_pkg::LEN_NONE;

        start_pos = pos_inc - POS_W'(len);

        q_entry.url_char = usf_pkg::is_url_char(c);
        // A prefix counts only below the saturated position and when it fits in the line.
        q_entry.pfx_ok   = below_cap && (len != usf_pkg::LEN_NONE) &&
                           (pos_inc >= POS_W'(len));
        q_entry.from_ok  = (CMP_W'(start_pos) >= CMP_W'(chars.payload.search_from));
        q_entry.last     = chars.payload.last_of_line;
        q_entry.start_pos = start_pos;
        q_entry.at_pos    = pos_reg;
        q_entry.past_pos  = below_cap ? pos_inc : pos_reg;

        chars.ready = !q_full;
        q_push      = chars.valid && !q_full;

        pos_next  = pos_reg;
        hist_next = hist_reg;
        if (q_push)
        begin
            if (chars.payload.last_of_line)
            begin
                pos_next = '0;
                for (int k = 0; k < usf_pkg::HIST_DEPTH; k++)
                    hist_next[k] = '0;
            end
            else
            begin
                pos_next = q_entry.past_pos;
                for (int k = usf_pkg::HIST_DEPTH - 1; k > 0; k--)
                    hist_next[k] = hist_reg[k - 1];
                hist_next[0] = c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int k = 0; k < usf_pkg::HIST_DEPTH; k++)
                hist_reg[k] <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            hist_reg <= hist_next;
        end
    end

endmodule

// ----- hw/rtl/usf_queue.sv -----
// Short queue of classified characters between front and back end.
// Depends on usf_pkg for its depth.
module usf_queue #(
    parameter type entry_t = logic
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   valid,
    output entry_t pop_entry
);

    localparam int DEPTH = usf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    entry_t           slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        valid     = (count_reg != '0);
        full      = (count_reg == CNT_W'(DEPTH));
        pop_entry = slots_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_W'(1);
        rd_ptr_next = rd_ptr_reg;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_W'(1);

        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ----- hw/rtl/usf_back.sv -----
// Back end: keeps the open-URL state, decides span results and holds them
// in the output register. Depends on usf_pkg and usf_chan_if.
module usf_back #(
    parameter int  POS_W = 13,
    parameter type cls_t = logic
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cls_t        q_entry,
    output logic        q_pop,
    usf_chan_if.source  spans
);

    localparam int CMP_W = (POS_W > 13) ? POS_W : 13;

    logic                in_url_reg, in_url_next;
    logic [11:0]         open_begin_reg, open_begin_next;
    logic [POS_W-1:0]    scan_floor_reg, scan_floor_next;
    logic                out_valid_reg, out_valid_next;
    usf_pkg::out_item_t  out_reg, out_next;

    logic             can_load;
    logic             closing, opening, url_now, emit;
    logic [11:0]      begin_now;
    logic [CMP_W-1:0] start_x, at_x, past_x;

    always_comb
    begin
        start_x = CMP_W'(q_entry.start_pos);
        at_x    = CMP_W'(q_entry.at_pos);
        past_x  = CMP_W'(q_entry.past_pos);

        can_load = !out_valid_reg || spans.ready;
        q_pop    = q_valid && can_load;

        closing = in_url_reg && !q_entry.url_char;
        // A prefix opens a URL only outside an open one and past the last span.
        opening = !in_url_reg && q_entry.pfx_ok && q_entry.from_ok &&
                  (q_entry.start_pos >= scan_floor_reg);
        url_now   = opening || (in_url_reg && !closing);
        begin_now = opening ? start_x[11:0] : open_begin_reg;
        emit      = closing || q_entry.last;

        out_next.found      = closing || url_now;
        out_next.span_begin = (closing || url_now) ? begin_now : 12'd0;
        out_next.span_end   = closing ? at_x[12:0] : (url_now ? past_x[12:0] : 13'd0);
        out_next.line_done  = q_entry.last;

        in_url_next     = in_url_reg;
        open_begin_next = open_begin_reg;
        scan_floor_next = scan_floor_reg;
        if (q_pop)
        begin
            in_url_next     = q_entry.last ? 1'b0 : url_now;
            open_begin_next = begin_now;
            if (q_entry.last)
                scan_floor_next = '0;
            else if (closing)
                scan_floor_next = q_entry.at_pos;
        end

        if (q_pop && emit)
            out_valid_next = 1'b1;
        else if (spans.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        spans.valid   = out_valid_reg;
        spans.payload = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_url_reg     <= 1'b0;
            open_begin_reg <= '0;
            scan_floor_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_url_reg     <= in_url_next;
            open_begin_reg <= open_begin_next;
            scan_floor_reg <= scan_floor_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
            out_reg <= out_next;
    end

endmodule

// ----- hw/rtl/url_span_finder.sv -----
// URL span finder top level: front end, queue and back end wired together.
// Depends on usf_pkg, usf_chan_if, usf_front, usf_queue and usf_back.
//
// Usage: characters of one text line arrive on the chars channel, one
// request each, with search_from and last_of_line. Every URL span that
// closes is sent on the spans channel with found=1; the final character of
// a line always yields the line's last result with line_done=1 (found=0 if
// no URL was open). Lines without characters give nothing.
// Throughput: one character per cycle while the queue has room, set by the
// per-character compare and class test in the front end and the single
// open-URL update in the back end. A result is registered in a queue slot,
// then in the output register, before it turns valid.
// Reset clears the line position, character history, open-URL state, queue
// pointers and count, and output valid flag; the block accepts right away.
// When the receiver stalls the result holds in the output register, the
// back end stops, the two-entry queue fills, and then chars.ready drops.
module url_span_finder #(
    parameter int MAX_LINE_LEN = usf_pkg::MAX_LINE_LEN_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    usf_chan_if.sink    chars,
    usf_chan_if.source  spans
);

    localparam int POS_W = $clog2(MAX_LINE_LEN + 1);

    typedef struct packed {
        logic             url_char;
        logic             pfx_ok;
        logic             from_ok;
        logic             last;
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] at_pos;
        logic [POS_W-1:0] past_pos;
    } cls_t;

    logic q_push, q_full, q_pop, q_valid;
    cls_t push_entry, pop_entry;

    usf_front #(
        .MAX_LEN (MAX_LINE_LEN),
        .POS_W   (POS_W),
        .cls_t   (cls_t)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (push_entry)
    );

    usf_queue #(
        .entry_t (cls_t)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .pop_entry  (pop_entry)
    );

    usf_back #(
        .POS_W (POS_W),
        .cls_t (cls_t)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (pop_entry),
        .q_pop   (q_pop),
        .spans   (spans)
    );

endmodule

// ----- hw/rtl/usf_checker.sv -----
// Port-level checks for the URL span finder, bound to its top level.
// Depends on usf_pkg and url_span_finder_macros.svh.
`include "url_span_finder_macros.svh"

module usf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               chars_valid,
    input logic               chars_ready,
    input logic               spans_valid,
    input logic               spans_ready,
    input usf_pkg::out_item_t spans_payload
);

    // Requests accepted minus results delivered; exact until it saturates.
    logic [7:0] credit_reg;
    logic       credit_sat_reg;
    logic       in_take, out_take;
    logic       stalled_now, empty_result, clean_end, valid_counted, owed;

    assign in_take  = chars_valid && chars_ready;
    assign out_take = spans_valid && spans_ready;

    assign stalled_now   = spans_valid && !spans_ready;
    assign empty_result  = spans_valid && !spans_payload.found;
    assign clean_end     = spans_payload.line_done && (spans_payload.span_begin == 12'd0) &&
                           (spans_payload.span_end == 13'd0);
    assign valid_counted = spans_valid && !credit_sat_reg;
    assign owed          = (credit_reg != 8'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg     <= '0;
            credit_sat_reg <= 1'b0;
        end
        else if (!credit_sat_reg)
        begin
            if (in_take && !out_take)
            begin
                credit_reg <= credit_reg + 8'd1;
                if (credit_reg == 8'hFE)
                    credit_sat_reg <= 1'b1;
            end
            else if (out_take && !in_take)
                credit_reg <= credit_reg - 8'd1;
        end
    end

    `USF_ASSERT_NEXT(a_valid_hold, stalled_now, spans_valid, "result dropped while stalled")
    `USF_ASSERT_NEXT(a_payload_hold, stalled_now, $stable(spans_payload), "result changed")
    `USF_ASSERT_SAME(a_no_url_line_end, empty_result, clean_end, "empty result is not a line end")
    `USF_ASSERT_SAME(a_result_has_request, valid_counted, owed, "result with no request")

endmodule

bind url_span_finder usf_checker u_usf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .chars_valid   (chars.valid),
    .chars_ready   (chars.ready),
    .spans_valid   (spans.valid),
    .spans_ready   (spans.ready),
    .spans_payload (spans.payload)
);

// ----- bench/url_span_finder_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for url_span_finder: streams text lines one character per request
// and checks every span against a typed result or the bench's line-scanning predictor.
// Depends on usf_pkg, usf_chan_if and the url_span_finder RTL.
module url_span_finder_tb;

    localparam int LINE_CAP = usf_pkg::MAX_LINE_LEN_DEFAULT;

    typedef enum int {PFX_FTP, PFX_HTTP, PFX_HTTPS} prefix_kind_t;

    typedef struct packed {
        logic [15:0]        ch;
        logic [12:0]        search_from;
        logic               last_of_line;
        logic               typed;
        usf_pkg::out_item_t result;
    } stim_row_t;

    // Results are typed in only where they can be read straight off the line.
    localparam stim_row_t DIRECTED [23] = '{
        '{16'hFFFF,          13'd0,    1'b1, 1'b1, '{1'b0, 12'd0, 13'd0,  1'b1}},
        '{usf_pkg::CH_F,     13'd0,    1'b0, 1'b0, '0},
        '{usf_pkg::CH_T,     13'd0,    1'b0, 1'b0, '0},
        '{usf_pkg::CH_P,     13'd0,    1'b0, 1'b0, '0},
        '{usf_pkg::CH_COLON, 13'd0,    1'b1, 1'b1, '{1'b1, 12'd0, 13'd4,  1'b1}},
        '{usf_pkg::CH_H,     13'd0,    1'b0, 1'b0, '0},
        '{usf_pkg::CH_T,     13'd0,    1'b0, 1'b0, '0},
        '{usf_pkg::CH_T,     13'd0,    1'b0, 1'b0, '0},
        '{usf_pkg::CH_P,     13'd0,    1'b0, 1'b0, '0},
        '{usf_pkg::CH_S,     13'd0,    1'b0, 1'b0, '0},
        '{usf_pkg::CH_COLON, 13'd0,    1'b0, 1'b0, '0},
        '{usf_pkg::CH_H,     13'd0,    1'b0, 1'b0, '0},
        '{usf_pkg::CH_T,     13'd0,    1'b0, 1'b0, '0},
        '{usf_pkg::CH_T,     13'd0,    1'b0, 1'b0, '0},
        '{usf_pkg::CH_P,     13'd0,    1'b0, 1'b0, '0},
        '{usf_pkg::CH_COLON, 13'd0,    1'b0, 1'b0, '0},
        '{usf_pkg::CH_TILDE, 13'd0,    1'b0, 1'b0, '0},
        '{16'h0000,          13'd0,    1'b1, 1'b1, '{1'b1, 12'd0, 13'd12, 1'b1}},
        '{usf_pkg::CH_H,     13'h1FFF, 1'b0, 1'b0, '0},
        '{usf_pkg::CH_T,     13'h1FFF, 1'b0, 1'b0, '0},
        '{usf_pkg::CH_T,     13'h1FFF, 1'b0, 1'b0, '0},
        '{usf_pkg::CH_P,     13'h1FFF, 1'b0, 1'b0, '0},
        '{usf_pkg::CH_COLON, 13'h1FFF, 1'b1, 1'b1, '{1'b0, 12'd0, 13'd0,  1'b1}}
    };

    logic clk = 1'b0;
    logic rst_n;

    usf_chan_if #(.payload_t(usf_pkg::in_item_t))  chars_if ();
    usf_chan_if #(.payload_t(usf_pkg::out_item_t)) spans_if ();

    url_span_finder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars_if),
        .spans (spans_if)
    );

    always #5 clk = ~clk;

    // Line scanner state.
    logic [12:0] line_pos;
    logic [15:0] recent_chars [usf_pkg::HIST_DEPTH];
    logic        url_open;
    logic [11:0] url_begin;
    logic [12:0] span_floor;

    usf_pkg::out_item_t expected_spans [$];
    logic [15:0]        line_chars [$];
    int                 mismatches = 0;
    int                 chars_sent = 0;
    bit                 no_gaps = 1'b0;

    function automatic bit is_link_char(input logic [15:0] c);
        return (c >= 16'd97 && c <= 16'd122) || (c >= 16'd65 && c <= 16'd90) ||
               (c >= 16'd44 && c <= 16'd59) || (c >= 16'd36 && c <= 16'd38) ||
               c == usf_pkg::CH_TILDE || c == usf_pkg::CH_UNDER || c == usf_pkg::CH_BANG ||
               c == usf_pkg::CH_EQ || c == usf_pkg::CH_STAR || c == usf_pkg::CH_QUEST ||
               c == usf_pkg::CH_HASH;
    endfunction

    // Length of the scheme prefix that the colon c would complete.
    function automatic int prefix_length(input logic [15:0] c);
        if (c != usf_pkg::CH_COLON)
        begin
            return int'(usf_pkg::LEN_NONE);
        end
        if (recent_chars[0] == usf_pkg::CH_S && recent_chars[1] == usf_pkg::CH_P &&
            recent_chars[2] == usf_pkg::CH_T && recent_chars[3] == usf_pkg::CH_T &&
            recent_chars[4] == usf_pkg::CH_H)
        begin
            return int'(usf_pkg::LEN_HTTPS);
        end
        if (recent_chars[0] == usf_pkg::CH_P && recent_chars[1] == usf_pkg::CH_T &&
            recent_chars[2] == usf_pkg::CH_T && recent_chars[3] == usf_pkg::CH_H)
        begin
            return int'(usf_pkg::LEN_HTTP);
        end
        if (recent_chars[0] == usf_pkg::CH_P && recent_chars[1] == usf_pkg::CH_T &&
            recent_chars[2] == usf_pkg::CH_F)
        begin
            return int'(usf_pkg::LEN_FTP);
        end
        return int'(usf_pkg::LEN_NONE);
    endfunction

    function automatic void clear_line_state();
        line_pos = '0;
        for (int k = 0; k < usf_pkg::HIST_DEPTH; k++)
        begin
            recent_chars[k] = '0;
        end
        url_open   = 1'b0;
        span_floor = '0;
    endfunction

    function automatic bit scan_char(input usf_pkg::in_item_t it,
                                     output usf_pkg::out_item_t res);
        int cur;
        int nxt;
        int plen;
        int start;
        int k;
        bit emit;
        cur  = int'(line_pos);
        nxt  = (cur < LINE_CAP) ? cur + 1 : LINE_CAP;
        emit = 1'b0;
        res  = '0;
        if (url_open)
        begin
            if (!is_link_char(it.ch))
            begin
                emit           = 1'b1;
                res.found      = 1'b1;
                res.span_begin = url_begin;
                res.span_end   = 13'(cur);
                url_open       = 1'b0;
                span_floor     = 13'(cur);
            end
        end
        else if (cur < LINE_CAP)
        begin
            plen = prefix_length(it.ch);
            if (plen != 0 && cur + 1 >= plen)
            begin
                start = cur + 1 - plen;
                if (start >= int'(it.search_from) && start >= int'(span_floor))
                begin
                    url_open  = 1'b1;
                    url_begin = 12'(start);
                end
            end
        end
        for (k = usf_pkg::HIST_DEPTH - 1; k > 0; k--)
        begin
            recent_chars[k] = recent_chars[k - 1];
        end
        recent_chars[0] = it.ch;
        line_pos = 13'(nxt);
        // A line end with no span closing here always reports the open URL or found=0.
        if (it.last_of_line && !emit)
        begin
            emit = 1'b1;
            if (url_open)
            begin
                res.found      = 1'b1;
                res.span_begin = url_begin;
                res.span_end   = 13'(nxt);
            end
        end
        res.line_done = it.last_of_line;
        if (it.last_of_line)
        begin
            clear_line_state();
        end
        return emit;
    endfunction

    function automatic string prefix_text(input prefix_kind_t kind);
        case (kind)
            PFX_FTP:  return "ftp:";
            PFX_HTTP: return "http:";
            default:  return "https:";
        endcase
    endfunction

    function automatic void add_text(input string s, input int keep);
        for (int k = 0; k < s.len() && k < keep; k++)
        begin
            line_chars.push_back({8'h00, s[k]});
        end
    endfunction

    function automatic logic [15:0] link_char();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(97, 122));
            1: return 16'($urandom_range(65, 90));
            2: return 16'($urandom_range(44, 59));
            3: return 16'($urandom_range(36, 38));
            default:
            begin
                case ($urandom_range(0, 6))
                    0: return usf_pkg::CH_TILDE;
                    1: return usf_pkg::CH_UNDER;
                    2: return usf_pkg::CH_BANG;
                    3: return usf_pkg::CH_EQ;
                    4: return usf_pkg::CH_STAR;
                    5: return usf_pkg::CH_QUEST;
                    default: return usf_pkg::CH_HASH;
                endcase
            end
        endcase
    endfunction

    function automatic logic [15:0] stop_char();
        logic [15:0] c;
        if ($urandom_range(0, 3) == 0)
        begin
            return 16'($urandom_range(127, 65535));
        end
        do
            c = 16'($urandom_range(0, 126));
        while (is_link_char(c));
        return c;
    endfunction

    function automatic void add_body(input int count);
        repeat (count)
        begin
            line_chars.push_back(link_char());
        end
    endfunction

    function automatic void add_stops(input int count);
        repeat (count)
        begin
            line_chars.push_back(stop_char());
        end
    endfunction

    task automatic send_char(input usf_pkg::in_item_t it, input bit typed,
                             input usf_pkg::out_item_t typed_res);
        usf_pkg::out_item_t res;
        bit                 emit;
        if (!no_gaps && $urandom_range(0, 5) == 0)
        begin
            chars_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        chars_if.valid   <= 1'b1;
        chars_if.payload <= it;
        do
            @(posedge clk);
        while (!chars_if.ready);
        emit = scan_char(it, res);
        if (typed)
        begin
            expected_spans.push_back(typed_res);
        end
        else if (emit)
        begin
            expected_spans.push_back(res);
        end
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_line(input logic [12:0] from);
        usf_pkg::in_item_t it;
        for (int k = 0; k < line_chars.size(); k++)
        begin
            it.ch           = line_chars[k];
            it.search_from  = from;
            it.last_of_line = (k == line_chars.size() - 1);
            send_char(it, 1'b0, '0);
        end
        line_chars.delete();
    endtask

    // Holds the sender back until every span owed so far has come out.
    task automatic drain_spans();
        chars_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_spans.size() != 0);
    endtask

    task automatic send_random_line();
        int          target;
        int          pick;
        logic [12:0] from;
        target = ($urandom_range(0, 7) == 0) ? $urandom_range(31, 80) : $urandom_range(1, 30);
        while (line_chars.size() < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                add_text(prefix_text(prefix_kind_t'($urandom_range(0, 2))), 6);
                add_body($urandom_range(0, 8));
            end
            else if (pick < 50)
            begin
                // Schemes cut off at a random length; short ones can come out whole.
                add_text(prefix_text(prefix_kind_t'($urandom_range(0, 2))), $urandom_range(1, 5));
            end
            else if (pick < 70)
            begin
                add_stops(1);
            end
            else if (pick < 85)
            begin
                add_body(1);
            end
            else
            begin
                line_chars.push_back(16'($urandom));
            end
        end
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            from = 13'($urandom_range(0, line_chars.size()));
        end
        else if (pick < 8)
        begin
            from = '0;
        end
        else
        begin
            from = 13'($urandom_range(0, 8191));
        end
        send_line(from);
    endtask

    // Lines past the maximum length, where positions saturate.
    task automatic send_long_lines();
        add_stops(LINE_CAP - 8);
        add_text(prefix_text(PFX_HTTP), 6);
        add_body(110);
        send_line('0);

        add_stops(LINE_CAP - 5);
        add_text(prefix_text(PFX_FTP), 6);
        add_body(6);
        add_stops(1);
        add_text(prefix_text(PFX_HTTPS), 6);
        add_body(3);
        send_line(13'($urandom_range(0, LINE_CAP - 5)));

        // The colon lands on the saturated position and cannot open a URL.
        add_stops(LINE_CAP - 4);
        add_text(prefix_text(PFX_HTTP), 6);
        add_body(5);
        send_line('0);
    endtask

    initial
    begin
        int base;
        rst_n            = 1'b0;
        chars_if.valid   = 1'b0;
        chars_if.payload = '0;
        clear_line_state();
        url_begin = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            send_char({DIRECTED[i].ch, DIRECTED[i].search_from, DIRECTED[i].last_of_line},
                      DIRECTED[i].typed, DIRECTED[i].result);
        end
        drain_spans();

        base = chars_sent;
        while (chars_sent < base + 420)
        begin
            send_random_line();
            if ($urandom_range(0, 15) == 0)
            begin
                drain_spans();
            end
        end
        drain_spans();

        no_gaps = 1'b1;
        send_long_lines();
        base = chars_sent;
        while (chars_sent < base + 80)
        begin
            send_random_line();
        end

        chars_if.valid <= 1'b0;
        while (expected_spans.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("url_span_finder verification clean");
        end
        else
        begin
            $display("url_span_finder verification failed");
        end
        $finish;
    end

    // Receiver: stalls in short bursts until the closing stretch of the run.
    initial
    begin
        int hold;
        spans_if.ready = 1'b0;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                spans_if.ready <= 1'b0;
                hold--;
            end
            else if (!no_gaps && $urandom_range(0, 4) == 0)
            begin
                spans_if.ready <= 1'b0;
                hold = $urandom_range(0, 2);
            end
            else
            begin
                spans_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        usf_pkg::out_item_t want;
        if (rst_n && spans_if.valid && spans_if.ready)
        begin
            if (expected_spans.size() == 0)
            begin
                $error("span result with none pending: found=%0d begin=%0d end=%0d done=%0d",
                       spans_if.payload.found, spans_if.payload.span_begin,
                       spans_if.payload.span_end, spans_if.payload.line_done);
                mismatches++;
            end
            else
            begin
                want = expected_spans.pop_front();
                if (spans_if.payload.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, spans_if.payload.found);
                    mismatches++;
                end
                if (spans_if.payload.span_begin !== want.span_begin)
                begin
                    $error("span_begin: expected %0d, got %0d",
                           want.span_begin, spans_if.payload.span_begin);
                    mismatches++;
                end
                if (spans_if.payload.span_end !== want.span_end)
                begin
                    $error("span_end: expected %0d, got %0d",
                           want.span_end, spans_if.payload.span_end);
                    mismatches++;
                end
                if (spans_if.payload.line_done !== want.line_done)
                begin
                    $error("line_done: expected %0d, got %0d",
                           want.line_done, spans_if.payload.line_done);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #5000000;
        $display("url_span_finder verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/usf_pkg.sv
hw/rtl/usf_chan_if.sv
hw/rtl/usf_front.sv
hw/rtl/usf_queue.sv
hw/rtl/usf_back.sv
hw/rtl/url_span_finder.sv
hw/rtl/usf_checker.sv
bench/url_span_finder_tb.sv
